### rtl/trsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transparent run-length sprite decoder.
// Used by the channel interfaces, the step logic and the top level.
package trsd_pkg;

   localparam int TRSD_COUNT_BITS = 24;   // default width of the byte counter
   localparam int DATA_W          = 8;
   localparam int ROW_W           = 8;
   localparam int COL_W           = 10;
   localparam int RUN_W           = 7;
   localparam int OUT_COUNT_W     = 24;
   localparam int CSR_IDX_W       = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // Decoder state carried from one item to the next.
   typedef struct packed {
      logic [RUN_W-1:0] run_left;
      logic [ROW_W-1:0] cur_row;
      logic [COL_W-1:0] cur_col;
      logic             leak_seen;
      logic             end_seen;
      logic             finished;
   } trsd_state_type;

   // One result item.
   typedef struct packed {
      logic                   pixel_write;
      logic [ROW_W-1:0]       pixel_row;
      logic [7:0]             pixel_col;
      logic [DATA_W-1:0]      pixel_color;
      logic                   image_done;
      logic                   leak_error;
      logic                   end_error;
      logic [OUT_COUNT_W-1:0] bytes_consumed;
   } trsd_result_type;

endpackage

### rtl/trsd_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the sprite decoder: input bytes, result
// items and configuration writes. Depends on trsd_pkg.
interface trsd_req_if import trsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              past_end;
   logic              start_of_image;

   modport source (output valid, data_byte, past_end, start_of_image, input ready);
   modport sink   (input valid, data_byte, past_end, start_of_image, output ready);
endinterface

interface trsd_rsp_if import trsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   pixel_write;
   logic [ROW_W-1:0]       pixel_row;
   logic [7:0]             pixel_col;
   logic [DATA_W-1:0]      pixel_color;
   logic                   image_done;
   logic                   leak_error;
   logic                   end_error;
   logic [OUT_COUNT_W-1:0] bytes_consumed;

   modport source (output valid, pixel_write, pixel_row, pixel_col, pixel_color,
                   image_done, leak_error, end_error, bytes_consumed, input ready);
   modport sink   (input valid, pixel_write, pixel_row, pixel_col, pixel_color,
                   image_done, leak_error, end_error, bytes_consumed, output ready);
endinterface

interface trsd_csr_if import trsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [7:0]           wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/trsd_step.sv
`timescale 1ns / 1ps
// Combinational step of the sprite decoder: next state, next byte count and
// the result item for one stream byte. Depends on trsd_pkg.
module trsd_step
   import trsd_pkg::*;
#(
   parameter int COUNT_BITS = TRSD_COUNT_BITS
) (
   input  trsd_state_type        state_i,
   input  logic [COUNT_BITS-1:0] count_i,
   input  logic [7:0]            image_width,
   input  logic [7:0]            image_height,
   input  logic [DATA_W-1:0]     data_byte,
   input  logic                  past_end,
   input  logic                  start_of_image,
   output trsd_state_type        state_o,
   output logic [COUNT_BITS-1:0] count_o,
   output trsd_result_type       result_o
);

   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

   function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] col,
                                                input logic [7:0] n);
      logic [COL_W:0] sum;
      sum = {1'b0, col} + (COL_W+1)'(n);
      return sum[COL_W] ? COL_MAX : sum[COL_W-1:0];
   endfunction

   // Once the row count reaches the height the picture is over; a pending run
   // counts as a leak.
   function automatic trsd_state_type done_check(input trsd_state_type st,
                                                 input logic [7:0] height);
      trsd_state_type r;
      r = st;
      if (r.cur_row >= height) begin
         if (r.run_left != '0) r.leak_seen = 1'b1;
         r.run_left = '0;
         r.finished = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      trsd_state_type        s;
      logic [COUNT_BITS-1:0] cnt;
      logic [DATA_W-1:0]     g;
      logic [COL_W-1:0]      width_c;
      logic [31:0]           cnt_wide;

      width_c  = COL_W'(image_width);
      s        = start_of_image ? '0 : state_i;
      cnt      = start_of_image ? '0 : count_i;
      result_o = '0;
      g        = past_end ? '0 : data_byte;

      s = done_check(s, image_height);

      if (!s.finished) begin
         if (cnt != {COUNT_BITS{1'b1}}) cnt = cnt + 1'b1;
         if (past_end) s.end_seen = 1'b1;

         if (s.run_left != '0 && s.cur_col >= width_c) begin
            s.leak_seen = 1'b1;
            s.run_left  = '0;
         end

         if (s.run_left != '0) begin
            if (!past_end) begin
               result_o.pixel_write = 1'b1;
               result_o.pixel_row   = s.cur_row;
               result_o.pixel_col   = s.cur_col[7:0];
               result_o.pixel_color = g;
            end
            s.cur_col  = col_add(s.cur_col, 8'd1);
            s.run_left = s.run_left - 1'b1;
            if (s.run_left != '0 && s.cur_col >= width_c) begin
               s.leak_seen = 1'b1;
               s.run_left  = '0;
            end
         end else if (g[7]) begin
            // Negative control: skip its magnitude in transparent columns.
            s.cur_col = col_add(s.cur_col, ~g + 8'd1);
         end else if (g == '0) begin
            s.cur_col = '0;
            s.cur_row = s.cur_row + 1'b1;
         end else begin
            s.run_left = g[RUN_W-1:0];
            // A run that starts beyond the width wraps to the next row.
            if (s.cur_col > width_c) begin
               s.cur_row   = s.cur_row + 1'b1;
               s.cur_col   = '0;
               s.leak_seen = 1'b1;
               s.run_left  = s.run_left - 1'b1;
               s = done_check(s, image_height);
            end
            if (s.run_left != '0 && s.cur_col >= width_c) begin
               s.leak_seen = 1'b1;
               s.run_left  = '0;
            end
         end
         s = done_check(s, image_height);
      end

      cnt_wide                = 32'(cnt);
      result_o.image_done     = s.finished;
      result_o.leak_error     = s.leak_seen;
      result_o.end_error      = s.end_seen;
      result_o.bytes_consumed = cnt_wide[OUT_COUNT_W-1:0];
      state_o                 = s;
      count_o                 = cnt;
   end

endmodule

### rtl/transparent_rle_sprite_decoder.sv
`timescale 1ns / 1ps
// Transparent run-length sprite decoder: one encoded byte in, one result out.
// Depends on trsd_pkg, trsd_channels and trsd_step.
//
// Usage:
//   req_ch carries one stream byte per item with its past-end and
//   start-of-image marks. rsp_ch returns exactly one item per input byte:
//   the pixel write (if any), the sticky done/leak/end flags and the
//   saturating count of bytes consumed for the current picture.
//   csr_ch writes image_width (index 0) and image_height (index 1); it is
//   always ready and should only be used while no item is in flight.
// Timing:
//   An accepted byte is held in the input register until the result register
//   can advance; then the step logic updates the decoder state and loads the
//   result register, which presents the result on rsp_ch. One byte per cycle
//   is sustained while rsp_ch is ready; the single state update per cycle
//   sets that figure.
// Reset and stalls:
//   Reset empties both registers, clears the decoder state and sets width
//   and height to 1. While rsp_ch is stalled the result register holds, and
//   an empty input register still takes one further item before req_ch.ready drops.
module transparent_rle_sprite_decoder
   import trsd_pkg::*;
#(
   parameter int COUNT_BITS = TRSD_COUNT_BITS
) (
   input logic          clock,
   input logic          reset,
   trsd_req_if.sink     req_ch,
   trsd_rsp_if.source   rsp_ch,
   trsd_csr_if.sink     csr_ch
);

   // Configuration registers.
   logic [7:0] width_ff,  width_in;
   logic [7:0] height_ff, height_in;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff,  in_data_in;
   logic              in_past_ff,  in_past_in;
   logic              in_start_ff, in_start_in;

   // Decoder state.
   trsd_state_type        state_ff, state_in, state_next;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_next;

   // Result register.
   logic            out_valid_ff, out_valid_in;
   trsd_result_type out_ff, out_in, step_result;

   logic advance;
   logic fire;
   logic req_take;

   trsd_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .state_i        (state_ff),
      .count_i        (count_ff),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .data_byte      (in_data_ff),
      .past_end       (in_past_ff),
      .start_of_image (in_start_ff),
      .state_o        (state_next),
      .count_o        (count_next),
      .result_o       (step_result)
   );

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.reg_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_ch.wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_ch.wdata;
            default: ;
         endcase
      end

      in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_data_in  = req_take ? req_ch.data_byte      : in_data_ff;
      in_past_in  = req_take ? req_ch.past_end       : in_past_ff;
      in_start_in = req_take ? req_ch.start_of_image : in_start_ff;

      state_in     = fire ? state_next  : state_ff;
      count_in     = fire ? count_next  : count_ff;
      out_in       = fire ? step_result : out_ff;
      out_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 8'd1;
         height_ff    <= 8'd1;
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_past_ff  <= in_past_in;
      in_start_ff <= in_start_in;
      out_ff      <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.pixel_write    = out_ff.pixel_write;
   assign rsp_ch.pixel_row      = out_ff.pixel_row;
   assign rsp_ch.pixel_col      = out_ff.pixel_col;
   assign rsp_ch.pixel_color    = out_ff.pixel_color;
   assign rsp_ch.image_done     = out_ff.image_done;
   assign rsp_ch.leak_error     = out_ff.leak_error;
   assign rsp_ch.end_error      = out_ff.end_error;
   assign rsp_ch.bytes_consumed = out_ff.bytes_consumed;

   // A finished picture never has a run pending.
   a_no_run_when_done: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |-> state_ff.run_left == '0)
      else $error("run pending after picture finished");

   // No pixel is written in an item that reports the picture as done.
   a_write_not_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.pixel_write |-> !out_ff.image_done)
      else $error("pixel write reported with image done");

   // The past-end flag stays set until a new picture starts.
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.end_seen && !(fire && in_start_ff) |=> state_ff.end_seen)
      else $error("end flag cleared without start of image");

endmodule
